### rtl/c3r_pkg.sv
// c3r_pkg: shared constants, request codes and the queue job type for the
// streaming 3x3 convolution block. No dependencies.
package c3r_pkg;

  // image and filter bank geometry
  localparam int IMG_SIZE = 28;
  localparam int NUM_FILT = 8;
  localparam int KERNEL   = 3;
  localparam int TAPS     = KERNEL * KERNEL;

  // field widths fixed by the channel payloads
  localparam int FILT_W = 3;
  localparam int TAP_W  = 4;
  localparam int PIX_W  = 16;
  localparam int POS_W  = 5;
  localparam int PROD_W = 2 * PIX_W;
  localparam int PSUM_W = PROD_W + 2;
  localparam int SUM_W  = 36;
  localparam int ACT_W  = SUM_W - 1;

  // line buffer column index
  localparam int COL_AW = $clog2(IMG_SIZE);

  // front-to-back job queue
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);

  // request codes
  localparam logic REQ_WEIGHT = 1'b0;
  localparam logic REQ_PIXEL  = 1'b1;

  // one unit of work for the back end: a weight write or a full window
  typedef struct packed {
    logic                             kind;
    logic [TAPS-1:0][PIX_W-1:0]       win;
    logic [POS_W-1:0]                 row;
    logic [POS_W-1:0]                 col;
    logic [FILT_W-1:0]                filt;
    logic [TAP_W-1:0]                 tap;
    logic [PIX_W-1:0]                 wval;
  } job_t;

endpackage

### rtl/c3r_ifs.sv
// c3r_ifs: valid/ready channel interfaces for requests and results.
// Depends on c3r_pkg for the payload widths.
interface c3r_in_if import c3r_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     req_type;
  logic [FILT_W-1:0]        weight_filter;
  logic [TAP_W-1:0]         weight_tap;
  logic signed [PIX_W-1:0]  weight_value;
  logic signed [PIX_W-1:0]  pixel_value;

  modport source (output valid, req_type, weight_filter, weight_tap, weight_value,
                  pixel_value, input ready);
  modport sink   (input valid, req_type, weight_filter, weight_tap, weight_value,
                  pixel_value, output ready);
endinterface

interface c3r_out_if import c3r_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [FILT_W-1:0]        filter_index;
  logic [POS_W-1:0]         out_row;
  logic [POS_W-1:0]         out_col;
  logic signed [SUM_W-1:0]  raw_sum;
  logic [ACT_W-1:0]         activation;
  logic                     last_of_run;

  modport source (output valid, filter_index, out_row, out_col, raw_sum,
                  activation, last_of_run, input ready);
  modport sink   (input valid, filter_index, out_row, out_col, raw_sum,
                  activation, last_of_run, output ready);
endinterface

### rtl/conv3x3_relu_stream.sv
// conv3x3_relu_stream: top level of the streaming 3x3 convolution with ReLU.
// Depends on c3r_pkg, c3r_ifs, c3r_front, c3r_queue, c3r_back.
//
// Pixels of a 28x28 image arrive in raster order on in_ch (req_type pixel),
// weights of the 8 filters arrive as weight items and may be mixed freely
// with pixels; each takes effect for every pixel accepted after it. A pixel
// whose row and column are both at least 2 yields 8 results on out_ch, one
// per filter in order, with last_of_run on filter 7; each is the exact
// 36-bit Q27 window sum and its ReLU. Such a pixel passes the back end one
// filter per cycle while the result channel is not stalled, a rate set by
// the single row read port of the weight store; a weight item leaves the
// queue once written there, and a border pixel never reaches it. Requests
// keep being accepted while results drain, through a 4-entry job queue. A
// result passes the queue, row read, products, row sums and window sum.
// Weights must be written before any pixel whose result uses them.
module conv3x3_relu_stream import c3r_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  c3r_in_if.sink      in_ch,
  c3r_out_if.source   out_ch
);

  logic  q_full, q_push, q_pop, q_head_valid;
  job_t  q_push_job, q_head;

  c3r_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .q_full   (q_full),
    .push     (q_push),
    .push_job (q_push_job)
  );

  c3r_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_job   (q_push_job),
    .pop        (q_pop),
    .full       (q_full),
    .head_valid (q_head_valid),
    .head       (q_head)
  );

  c3r_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (q_head_valid),
    .head       (q_head),
    .pop        (q_pop),
    .out_ch     (out_ch)
  );

endmodule

### rtl/c3r_front.sv
// c3r_front: accepts requests, keeps the line buffer, window and position
// counters, and turns each request with work for the back end into a queue job. Depends on c3r_pkg, c3r_ifs.
module c3r_front import c3r_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  c3r_in_if.sink     in_ch,
  input  logic       q_full,
  output logic       push,
  output job_t       push_job
);

  logic [PIX_W-1:0]                 line0_r [IMG_SIZE];
  logic [PIX_W-1:0]                 line1_r [IMG_SIZE];
  logic [TAPS-1:0][PIX_W-1:0]       win_r;
  logic [TAPS-1:0][PIX_W-1:0]       win_nxt;
  logic [POS_W-1:0]                 row_r, row_nxt;
  logic [POS_W-1:0]                 col_r, col_nxt;
  logic [COL_AW-1:0]                cidx;
  logic                             xfer;
  logic                             is_pixel;
  logic                             wr_ok;
  logic                             emit;

  assign in_ch.ready = !q_full;
  assign xfer        = in_ch.valid && in_ch.ready;
  assign is_pixel    = (in_ch.req_type == REQ_PIXEL);
  assign cidx        = col_r[COL_AW-1:0];

  // drop weight writes that point outside the bank
  assign wr_ok = (32'(in_ch.weight_filter) < NUM_FILT) && (32'(in_ch.weight_tap) < TAPS);
  assign emit  = (row_r >= POS_W'(KERNEL - 1)) && (col_r >= POS_W'(KERNEL - 1));

  // shift the window one column left and bring in the new column
  always_comb begin
    for (int k = 0; k < KERNEL; k++) begin
      win_nxt[k*KERNEL + 0] = win_r[k*KERNEL + 1];
      win_nxt[k*KERNEL + 1] = win_r[k*KERNEL + 2];
    end
    win_nxt[0*KERNEL + 2] = line0_r[cidx];
    win_nxt[1*KERNEL + 2] = line1_r[cidx];
    win_nxt[2*KERNEL + 2] = in_ch.pixel_value;
  end

  // advance the raster position, wrapping at the image edges
  always_comb begin
    col_nxt = col_r + POS_W'(1);
    row_nxt = row_r;
    if (col_r == POS_W'(IMG_SIZE - 1)) begin
      col_nxt = '0;
      row_nxt = (row_r == POS_W'(IMG_SIZE - 1)) ? '0 : row_r + POS_W'(1);
    end
  end

  // build the job and push only when the back end has work to do
  always_comb begin
    push_job.kind = in_ch.req_type;
    push_job.win  = win_nxt;
    push_job.row  = row_r - POS_W'(KERNEL - 1);
    push_job.col  = col_r - POS_W'(KERNEL - 1);
    push_job.filt = in_ch.weight_filter;
    push_job.tap  = in_ch.weight_tap;
    push_job.wval = in_ch.weight_value;
    push          = xfer && (is_pixel ? emit : wr_ok);
  end

  // position counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
      col_r <= '0;
    end else if (xfer && is_pixel) begin
      row_r <= row_nxt;
      col_r <= col_nxt;
    end
  end

  // line buffer and window storage
  always_ff @(posedge clk) begin
    if (xfer && is_pixel) begin
      win_r         <= win_nxt;
      line0_r[cidx] <= line1_r[cidx];
      line1_r[cidx] <= in_ch.pixel_value;
    end
  end

endmodule

### rtl/c3r_queue.sv
// c3r_queue: short FIFO of jobs between the front and back ends.
// Depends on c3r_pkg.
module c3r_queue import c3r_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  job_t  push_job,
  input  logic  pop,
  output logic  full,
  output logic  head_valid,
  output job_t  head
);

  job_t              mem_r [Q_DEPTH];
  logic [Q_AW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [Q_AW:0]     cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign full       = (cnt_r == (Q_AW+1)'(Q_DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head       = mem_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) cnt_nxt = cnt_r + (Q_AW+1)'(1);
    if (do_pop && !do_push) cnt_nxt = cnt_r - (Q_AW+1)'(1);
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + Q_AW'(1);
      if (do_pop)  rd_ptr_r <= rd_ptr_r + Q_AW'(1);
      cnt_r <= cnt_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_job;
  end

endmodule

### rtl/c3r_back.sv
// c3r_back: weight store and MAC pipeline that, unless stalled, issues one
// filter per cycle into the result register. Depends on c3r_pkg, c3r_ifs.
module c3r_back import c3r_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       head_valid,
  input  job_t       head,
  output logic       pop,
  c3r_out_if.source  out_ch
);

  typedef struct packed {
    logic [FILT_W-1:0] filt;
    logic [POS_W-1:0]  row;
    logic [POS_W-1:0]  col;
    logic              last;
  } meta_t;

  // weight store: one row per filter, written one tap at a time
  logic [TAPS-1:0][PIX_W-1:0]       wmem_r [NUM_FILT];
  logic [TAPS-1:0][PIX_W-1:0]       wrow_r;

  logic [FILT_W-1:0]                fcnt_r;
  logic                             en;
  logic                             issue_w, issue_p, fl_last;

  logic                             s1_v_r, s2_v_r, s3_v_r, s4_v_r;
  meta_t                            s1_m_r, s2_m_r, s3_m_r, s4_m_r;
  logic [TAPS-1:0][PIX_W-1:0]       s1_win_r;
  logic signed [PROD_W-1:0]         prod_r [TAPS];
  logic signed [PSUM_W-1:0]         psum_r [KERNEL];
  logic signed [PSUM_W-1:0]         psum_nxt [KERNEL];
  logic signed [SUM_W-1:0]          sum_r, sum_nxt;
  logic [ACT_W-1:0]                 act_r;

  // the whole pipeline moves when the result register is free or drains
  assign en      = !s4_v_r || out_ch.ready;
  assign issue_w = en && head_valid && (head.kind == REQ_WEIGHT);
  assign issue_p = en && head_valid && (head.kind == REQ_PIXEL);
  assign fl_last = (fcnt_r == FILT_W'(NUM_FILT - 1));
  assign pop     = issue_w || (issue_p && fl_last);

  // filter sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fcnt_r <= '0;
    end else if (issue_p) begin
      fcnt_r <= fl_last ? '0 : fcnt_r + FILT_W'(1);
    end
  end

  // weight write and registered row read
  always_ff @(posedge clk) begin
    if (issue_w) wmem_r[head.filt][head.tap] <= head.wval;
    if (issue_p) wrow_r <= wmem_r[fcnt_r];
  end

  // partial sums over each kernel row, then the full window sum
  always_comb begin
    for (int g = 0; g < KERNEL; g++) begin
      psum_nxt[g] = PSUM_W'(prod_r[g*KERNEL]) + PSUM_W'(prod_r[g*KERNEL + 1])
                  + PSUM_W'(prod_r[g*KERNEL + 2]);
    end
    sum_nxt = SUM_W'(psum_r[0]) + SUM_W'(psum_r[1]) + SUM_W'(psum_r[2]);
  end

  // stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= issue_p;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
      s4_v_r <= s3_v_r;
    end
  end

  // stage payloads
  always_ff @(posedge clk) begin
    if (en) begin
      s1_m_r.filt <= fcnt_r;
      s1_m_r.row  <= head.row;
      s1_m_r.col  <= head.col;
      s1_m_r.last <= fl_last;
      s1_win_r    <= head.win;
      for (int k = 0; k < TAPS; k++) begin
        prod_r[k] <= $signed(s1_win_r[k]) * $signed(wrow_r[k]);
      end
      s2_m_r <= s1_m_r;
      for (int g = 0; g < KERNEL; g++) begin
        psum_r[g] <= psum_nxt[g];
      end
      s3_m_r <= s2_m_r;
      sum_r  <= sum_nxt;
      act_r  <= (sum_nxt > 0) ? sum_nxt[ACT_W-1:0] : '0;
      s4_m_r <= s3_m_r;
    end
  end

  assign out_ch.valid        = s4_v_r;
  assign out_ch.filter_index = s4_m_r.filt;
  assign out_ch.out_row      = s4_m_r.row;
  assign out_ch.out_col      = s4_m_r.col;
  assign out_ch.raw_sum      = sum_r;
  assign out_ch.activation   = act_r;
  assign out_ch.last_of_run  = s4_m_r.last;

endmodule

### rtl/c3r_checker.sv
// c3r_checker: port-level checks on the result channel, bound to the top
// level. Depends on c3r_pkg and conv3x3_relu_stream.
module c3r_checker import c3r_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     out_valid,
  input  logic                     out_ready,
  input  logic [FILT_W-1:0]        filter_index,
  input  logic [POS_W-1:0]         out_row,
  input  logic [POS_W-1:0]         out_col,
  input  logic signed [SUM_W-1:0]  raw_sum,
  input  logic [ACT_W-1:0]         activation,
  input  logic                     last_of_run
);

  // no result is offered right after reset
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // hold a stalled result
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(raw_sum)
      && $stable(filter_index) && $stable(last_of_run))
    else $error("stalled result changed");

  // the filters of one run follow each other without gaps
  a_run_contig: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !last_of_run |=> out_valid
      && filter_index == FILT_W'($past(filter_index) + FILT_W'(1))
      && $stable(out_row) && $stable(out_col))
    else $error("run of filter results broken");

  // activation is the ReLU of the sum, and the run ends on the last filter
  a_relu: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (activation == ((raw_sum > 0) ? raw_sum[ACT_W-1:0]
                                                : ACT_W'(0)))
      && (last_of_run == (filter_index == FILT_W'(NUM_FILT - 1))))
    else $error("activation or run end mismatch");

endmodule

bind conv3x3_relu_stream c3r_checker u_c3r_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .filter_index (out_ch.filter_index),
  .out_row      (out_ch.out_row),
  .out_col      (out_ch.out_col),
  .raw_sum      (out_ch.raw_sum),
  .activation   (out_ch.activation),
  .last_of_run  (out_ch.last_of_run)
);
